### rtl/note_word_parser_unit_defines.svh
// assertion helpers for the note word parser checker
`ifndef NOTE_WORD_PARSER_UNIT_DEFINES_SVH
`define NOTE_WORD_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define NWP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("note word parser: same-cycle check failed");

// next-cycle implication, checked on every rising clock edge outside reset
`define NWP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("note word parser: next-cycle check failed");

`endif

### rtl/nwp_pkg.sv
package nwp_pkg;

    // word buffer size, a word may hold one character less
    localparam int unsigned TOKEN_BUFFER_BYTES = 16;
    localparam int unsigned CNT_W = $clog2(TOKEN_BUFFER_BYTES);

    // result kinds
    localparam logic [1:0] KIND_NOTE = 2'd0;
    localparam logic [1:0] KIND_CTRL = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // divider geometry
    localparam int unsigned DIVIDEND_W = 20;
    localparam int unsigned DIVISOR_W  = 16;
    localparam int unsigned STEP_W     = $clog2(DIVIDEND_W + 1);

    // note frequency table, index = (octave - 1) * 12 + semitone
    localparam int unsigned FREQ_ENTRIES = 98;
    localparam logic [15:0] FREQ_TABLE [0:FREQ_ENTRIES-1] = '{
        16'd31,
        16'd33, 16'd35, 16'd37, 16'd39, 16'd41, 16'd44,
        16'd46, 16'd49, 16'd52, 16'd55, 16'd58, 16'd62,
        16'd65, 16'd69, 16'd73, 16'd78, 16'd82, 16'd87,
        16'd92, 16'd98, 16'd104, 16'd110, 16'd117, 16'd123,
        16'd131, 16'd139, 16'd147, 16'd156, 16'd165, 16'd175,
        16'd185, 16'd196, 16'd208, 16'd220, 16'd233, 16'd247,
        16'd262, 16'd277, 16'd294, 16'd311, 16'd330, 16'd349,
        16'd370, 16'd392, 16'd415, 16'd440, 16'd466, 16'd494,
        16'd523, 16'd554, 16'd587, 16'd622, 16'd659, 16'd698,
        16'd740, 16'd784, 16'd831, 16'd880, 16'd932, 16'd988,
        16'd1047, 16'd1109, 16'd1175, 16'd1245, 16'd1319, 16'd1397,
        16'd1480, 16'd1568, 16'd1661, 16'd1760, 16'd1865, 16'd1976,
        16'd2093, 16'd2217, 16'd2349, 16'd2489, 16'd2637, 16'd2794,
        16'd2960, 16'd3136, 16'd3322, 16'd3520, 16'd3729, 16'd3951,
        16'd4186, 16'd4435, 16'd4699, 16'd4978, 16'd5274, 16'd5588,
        16'd5920, 16'd6272, 16'd6645, 16'd7040, 16'd7459, 16'd7902,
        16'd8372
    };

    // controller to datapath
    typedef struct packed {
        logic char_take;
        logic div_start;
        logic div_run;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_note;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

### rtl/nwp_ctrl.sv
module nwp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_last_char,
    input  nwp_pkg::t_dp_sts i_sts,
    output logic             o_in_stall,
    output nwp_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       take;

    assign o_in_stall = (r_state != ST_IDLE);
    assign take       = i_in_valid && (r_state == ST_IDLE);

    // next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.char_take = take;
        unique case (r_state)
            ST_IDLE: begin
                if (take && i_last_char) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_sts.is_note) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_OUT;
                end else begin
                    o_cmd.div_run = 1'b1;
                end
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/nwp_datapath.sv
module nwp_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_char_code,
    input  logic             i_out_stall,
    input  nwp_pkg::t_dp_cmd i_cmd,
    output nwp_pkg::t_dp_sts o_sts,
    output logic             o_out_valid,
    output logic [1:0]       o_word_kind,
    output logic [15:0]      o_freq_hz,
    output logic [15:0]      o_dur_ms,
    output logic [3:0]       o_vol_level
);

    localparam logic [3:0] PH_START = 4'd0;
    localparam logic [3:0] PH_LEN   = 4'd1;
    localparam logic [3:0] PH_CWANT = 4'd2;
    localparam logic [3:0] PH_CTRL  = 4'd3;
    localparam logic [3:0] PH_REST  = 4'd4;
    localparam logic [3:0] PH_NOTE  = 4'd5;
    localparam logic [3:0] PH_ACC   = 4'd6;
    localparam logic [3:0] PH_OCT   = 4'd7;
    localparam logic [3:0] PH_DOT   = 4'd8;

    localparam logic [1:0] CL_TEMPO  = 2'd0;
    localparam logic [1:0] CL_OCTAVE = 2'd1;
    localparam logic [1:0] CL_LENGTH = 2'd2;
    localparam logic [1:0] CL_VOLUME = 2'd3;

    localparam int unsigned DW = nwp_pkg::DIVIDEND_W;
    localparam int unsigned VW = nwp_pkg::DIVISOR_W;
    localparam int unsigned CW = nwp_pkg::CNT_W;

    localparam logic [16:0]   ACC_MAX   = 17'd100000;
    localparam logic [DW-1:0] NUM_PLAIN = DW'(480000);
    localparam logic [DW-1:0] NUM_DOT   = DW'(720000);

    // persistent settings
    logic [8:0]  r_tempo;
    logic [3:0]  r_def_oct;
    logic [5:0]  r_def_len;
    logic [3:0]  r_vol;
    // per-word parse state
    logic [3:0]  r_phase, n_phase;
    logic [CW-1:0] r_count, n_count;
    logic [16:0] r_acc, n_acc;
    logic [5:0]  r_len, n_len;
    logic [3:0]  r_oct, n_oct;
    logic [3:0]  r_semi, n_semi;
    logic        r_dot, n_dot;
    logic [1:0]  r_ctl, n_ctl;
    logic        r_rest, n_rest;
    logic        r_err, n_err;
    // divider
    logic [DW-1:0]     r_quo;
    logic [VW-1:0]     r_rem;
    logic [VW-1:0]     r_dvs;
    logic [nwp_pkg::STEP_W-1:0] r_step;
    // output register
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [15:0] r_freq;
    logic [15:0] r_dur;
    logic [3:0]  r_vol_out;

    logic [7:0]  c;
    logic        is_digit;
    logic [3:0]  digit;
    logic [16:0] acc_step;
    logic [16:0] acc_first;
    logic [3:0]  pc_plus;
    logic        err_now;
    logic        note_phase;
    logic        ctrl_ok;
    logic [1:0]  kind;
    logic [5:0]  len_sel;
    logic [3:0]  oct_sel;
    logic [3:0]  oct_m1;
    logic [6:0]  idx;
    logic [15:0] freq;
    logic [14:0] den;
    logic [VW:0] rem_sh;
    logic        q_bit;
    logic        out_free;

    // accumulate one decimal digit with saturation
    function automatic logic [16:0] acc_digit(input logic [16:0] acc, input logic [3:0] d);
        logic [20:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {17'd0, d};
        acc_digit = (v > {4'd0, ACC_MAX}) ? ACC_MAX : v[16:0];
    endfunction

    // pitch class plus one, zero when not a note letter
    function automatic logic [3:0] pitch_plus(input logic [7:0] ch);
        unique case (ch)
            "c":     pitch_plus = 4'd1;
            "d":     pitch_plus = 4'd3;
            "e":     pitch_plus = 4'd5;
            "f":     pitch_plus = 4'd6;
            "g":     pitch_plus = 4'd8;
            "a":     pitch_plus = 4'd10;
            "b":     pitch_plus = 4'd12;
            default: pitch_plus = 4'd0;
        endcase
    endfunction

    // fold upper case and decode the character
    assign c         = (i_char_code >= "A" && i_char_code <= "Z") ?
                       (i_char_code + 8'd32) : i_char_code;
    assign is_digit  = (c >= "0") && (c <= "9");
    assign digit     = c[3:0];
    assign acc_step  = acc_digit(r_acc, digit);
    assign acc_first = acc_digit(17'd0, digit);
    assign pc_plus   = pitch_plus(c);
    assign err_now   = r_err || (r_count >= CW'(nwp_pkg::TOKEN_BUFFER_BYTES - 1));

    // parse one character
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_acc   = r_acc;
        n_len   = r_len;
        n_oct   = r_oct;
        n_semi  = r_semi;
        n_dot   = r_dot;
        n_ctl   = r_ctl;
        n_rest  = r_rest;
        n_err   = err_now;
        if (!err_now) begin
            n_count = r_count + CW'(1);
            unique case (r_phase)
                PH_START, PH_LEN: begin
                    if (r_phase == PH_START &&
                        (c == "t" || c == "o" || c == "l" || c == "v")) begin
                        n_ctl   = (c == "t") ? CL_TEMPO :
                                  (c == "o") ? CL_OCTAVE :
                                  (c == "l") ? CL_LENGTH : CL_VOLUME;
                        n_phase = PH_CWANT;
                    end else if (is_digit) begin
                        n_acc   = (r_phase == PH_START) ? acc_first : acc_step;
                        n_phase = PH_LEN;
                    end else if (r_phase == PH_LEN &&
                                 (r_acc < 17'd1 || r_acc > 17'd32)) begin
                        n_err = 1'b1;
                    end else begin
                        if (r_phase == PH_LEN) begin
                            n_len = r_acc[5:0];
                        end
                        // rest or note letter
                        if (c == "r") begin
                            n_rest  = 1'b1;
                            n_phase = PH_REST;
                        end else if (pc_plus != 4'd0) begin
                            n_semi  = pc_plus;
                            n_phase = PH_NOTE;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                end
                PH_CWANT, PH_CTRL: begin
                    if (is_digit) begin
                        n_acc   = (r_phase == PH_CWANT) ? acc_first : acc_step;
                        n_phase = PH_CTRL;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_NOTE, PH_ACC: begin
                    if (r_phase == PH_NOTE && (c == "#" || c == "s")) begin
                        n_semi  = r_semi + 4'd1;
                        n_phase = PH_ACC;
                    end else if (r_phase == PH_NOTE && c == "b") begin
                        n_semi  = r_semi - 4'd1;
                        n_phase = PH_ACC;
                    end else if (is_digit) begin
                        // octave digit
                        if (digit < 4'd1 || digit > 4'd8) begin
                            n_err = 1'b1;
                        end else begin
                            n_oct   = digit;
                            n_phase = PH_OCT;
                        end
                    end else if (c == ".") begin
                        n_dot   = 1'b1;
                        n_phase = PH_DOT;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_OCT, PH_REST: begin
                    if (c == ".") begin
                        n_dot   = 1'b1;
                        n_phase = PH_DOT;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                default: begin
                    n_err = 1'b1;
                end
            endcase
        end
    end

    // word end evaluation
    assign note_phase = (r_phase == PH_REST) || (r_phase == PH_NOTE) ||
                        (r_phase == PH_ACC) || (r_phase == PH_OCT) || (r_phase == PH_DOT);

    always_comb begin
        unique case (r_ctl)
            CL_TEMPO:  ctrl_ok = (r_acc >= 17'd40) && (r_acc <= 17'd300);
            CL_OCTAVE: ctrl_ok = (r_acc >= 17'd1) && (r_acc <= 17'd8);
            CL_LENGTH: ctrl_ok = (r_acc >= 17'd1) && (r_acc <= 17'd32);
            CL_VOLUME: ctrl_ok = (r_acc <= 17'd15);
            default:   ctrl_ok = 1'b0;
        endcase
    end

    always_comb begin
        if (r_err) begin
            kind = nwp_pkg::KIND_ERR;
        end else if (r_phase == PH_CTRL) begin
            kind = ctrl_ok ? nwp_pkg::KIND_CTRL : nwp_pkg::KIND_ERR;
        end else if (note_phase) begin
            kind = nwp_pkg::KIND_NOTE;
        end else begin
            kind = nwp_pkg::KIND_ERR;
        end
    end

    // frequency lookup
    assign oct_sel = (r_oct != 4'd0) ? r_oct : r_def_oct;
    assign oct_m1  = oct_sel - 4'd1;
    assign idx     = {oct_m1[3:0], 3'b000} + {1'b0, oct_m1, 2'b00} + {3'b000, r_semi};
    assign freq    = (r_rest || oct_sel == 4'd0 ||
                      idx >= 7'(nwp_pkg::FREQ_ENTRIES)) ? 16'd0 : nwp_pkg::FREQ_TABLE[idx];

    // divisor base: tempo times length, doubled when the divider starts
    assign len_sel = (r_len != 6'd0) ? r_len : r_def_len;
    assign den     = 15'({6'd0, r_tempo} * {9'd0, len_sel});

    // one restoring step per cycle
    assign rem_sh  = {r_rem, r_quo[DW-1]};
    assign q_bit   = (rem_sh >= {1'b0, r_dvs});

    assign out_free       = !r_out_valid || !i_out_stall;
    assign o_sts.is_note  = (kind == nwp_pkg::KIND_NOTE);
    assign o_sts.div_done = (r_step == nwp_pkg::STEP_W'(DW));
    assign o_sts.out_free = out_free;

    // divider registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dvs  <= {den, 1'b0};
            r_quo  <= (r_dot ? NUM_DOT : NUM_PLAIN) + {5'd0, den};
            r_rem  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_run) begin
            r_rem  <= q_bit ? VW'(rem_sh - {1'b0, r_dvs}) : rem_sh[VW-1:0];
            r_quo  <= {r_quo[DW-2:0], q_bit};
            r_step <= r_step + nwp_pkg::STEP_W'(1);
        end
    end

    // settings and parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tempo   <= 9'd120;
            r_def_oct <= 4'd4;
            r_def_len <= 6'd4;
            r_vol     <= 4'd12;
            r_phase   <= PH_START;
            r_count   <= '0;
            r_acc     <= '0;
            r_len     <= '0;
            r_oct     <= '0;
            r_semi    <= '0;
            r_dot     <= 1'b0;
            r_ctl     <= CL_TEMPO;
            r_rest    <= 1'b0;
            r_err     <= 1'b0;
        end else if (i_cmd.out_load) begin
            // apply an accepted control word, then clear the word
            if (kind == nwp_pkg::KIND_CTRL) begin
                unique case (r_ctl)
                    CL_TEMPO:  r_tempo   <= r_acc[8:0];
                    CL_OCTAVE: r_def_oct <= r_acc[3:0];
                    CL_LENGTH: r_def_len <= r_acc[5:0];
                    CL_VOLUME: r_vol     <= r_acc[3:0];
                    default:   r_vol     <= r_vol;
                endcase
            end
            r_phase <= PH_START;
            r_count <= '0;
            r_acc   <= '0;
            r_len   <= '0;
            r_oct   <= '0;
            r_semi  <= '0;
            r_dot   <= 1'b0;
            r_ctl   <= CL_TEMPO;
            r_rest  <= 1'b0;
            r_err   <= 1'b0;
        end else if (i_cmd.char_take) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_acc   <= n_acc;
            r_len   <= n_len;
            r_oct   <= n_oct;
            r_semi  <= n_semi;
            r_dot   <= n_dot;
            r_ctl   <= n_ctl;
            r_rest  <= n_rest;
            r_err   <= n_err;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_kind <= kind;
            if (kind == nwp_pkg::KIND_NOTE) begin
                r_freq <= freq;
                r_dur  <= (r_quo[DW-1:16] != '0) ? 16'hFFFF : r_quo[15:0];
            end else begin
                r_freq <= 16'd0;
                r_dur  <= 16'd0;
            end
            r_vol_out <= (kind == nwp_pkg::KIND_CTRL && r_ctl == CL_VOLUME) ?
                         r_acc[3:0] : r_vol;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_word_kind = r_kind;
    assign o_freq_hz   = r_freq;
    assign o_dur_ms    = r_dur;
    assign o_vol_level = r_vol_out;

endmodule

### rtl/note_word_parser_unit.sv
// note word parser: one character per transfer, a result on the last character
// non-final characters of a word are taken back to back, with no stall between them
// after the last character, control and error words go through the eval and out states
// to the result register; notes and rests also run the 20-step bit-serial duration divider
// reset (synchronous, active low): tempo 120, octave 4, length 4, volume 12,
// word state cleared, no result pending
module note_word_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_char,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_word_kind,
    output logic [15:0] o_freq_hz,
    output logic [15:0] o_dur_ms,
    output logic [3:0]  o_vol_level
);

    nwp_pkg::t_dp_cmd cmd;
    nwp_pkg::t_dp_sts sts;

    // sequencing of char, divide and result steps
    nwp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_char (i_last_char),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    // parser, divider and output register
    nwp_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_code (i_char_code),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_word_kind (o_word_kind),
        .o_freq_hz   (o_freq_hz),
        .o_dur_ms    (o_dur_ms),
        .o_vol_level (o_vol_level)
    );

endmodule

### rtl/nwp_checker.sv
`include "note_word_parser_unit_defines.svh"

module nwp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_last_char,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_word_kind,
    input logic [15:0] o_freq_hz,
    input logic [15:0] o_dur_ms,
    input logic [3:0]  o_vol_level
);

    logic [37:0] out_payload;
    logic        nonnote_out;

    // result fields as one word, and a control or error result on offer
    assign out_payload = {o_word_kind, o_freq_hz, o_dur_ms, o_vol_level};
    assign nonnote_out = o_out_valid && (o_word_kind != nwp_pkg::KIND_NOTE);

    // a stalled result stays offered
    `NWP_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)

    // a stalled result keeps its payload
    `NWP_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(out_payload))

    // control and error results carry no frequency and no duration
    `NWP_ASSERT_NOW(a_nonnote_zero, nonnote_out, o_freq_hz == 16'd0 && o_dur_ms == 16'd0)

    // the end of a word holds off the next character
    `NWP_ASSERT_NEXT(a_word_end_busy, i_in_valid && !o_in_stall && i_last_char, o_in_stall)

endmodule

bind note_word_parser_unit nwp_checker u_nwp_checker (.*);

### tb/note_word_parser_unit_test.sv
module note_word_parser_unit_test;

    localparam int unsigned ACC_LIMIT      = 100000;
    localparam int unsigned TEMPO_MIN      = 40;
    localparam int unsigned TEMPO_MAX      = 300;
    localparam int unsigned OCTAVE_MAX     = 8;
    localparam int unsigned LENGTH_MAX     = 32;
    localparam int unsigned VOLUME_MAX     = 15;
    localparam int unsigned ITEM_TARGET    = 1850;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 40;
    localparam int unsigned CHUNK_WORDS    = 40;
    localparam int unsigned DIR_N          = 11;

    typedef enum logic [3:0] {
        P_START, P_LEN, P_CWANT, P_CTRL, P_REST, P_NOTE, P_ACC, P_OCT, P_DOT
    } t_parse_phase;

    typedef enum logic [1:0] {CTL_TEMPO, CTL_OCTAVE, CTL_LENGTH, CTL_VOLUME} t_control;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] freq;
        logic [15:0] dur;
        logic [3:0]  vol;
    } t_word_result;

    typedef struct packed {
        logic         typed;
        t_word_result res;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_char_code = 8'd0;
    logic        i_last_char = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_word_kind;
    logic [15:0] o_freq_hz;
    logic [15:0] o_dur_ms;
    logic [3:0]  o_vol_level;

    note_word_parser_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_word_kind (o_word_kind),
        .o_freq_hz   (o_freq_hz),
        .o_dur_ms    (o_dur_ms),
        .o_vol_level (o_vol_level)
    );

    // clock, period 12
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // settings kept across words
    logic [8:0]   tempo_q  = 9'd120;
    logic [3:0]   octave_q = 4'd4;
    logic [5:0]   length_q = 6'd4;
    logic [3:0]   volume_q = 4'd12;

    // state of the word in progress
    t_parse_phase word_phase = P_START;
    logic [4:0]   char_cnt   = 5'd0;
    logic [16:0]  digit_acc  = 17'd0;
    logic [5:0]   word_len   = 6'd0;
    logic [3:0]   word_oct   = 4'd0;
    logic [4:0]   semitone   = 5'd0;
    logic         dotted     = 1'b0;
    t_control     ctl_sel    = CTL_TEMPO;
    logic         is_rest    = 1'b0;
    logic         word_err   = 1'b0;

    t_word_result pending_words [$];
    logic [7:0]   word_chars [$];
    int unsigned  chars_sent  = 0;
    int unsigned  mismatches  = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  out_wait    = 0;
    bit           calm        = 1'b0;

    string note_letters = "cdefgab";
    string accidentals  = "#sb";
    string ctl_letters  = "tolv";
    int unsigned limit_vals [12] = '{0, 1, 8, 9, 15, 16, 32, 33, 39, 40, 300, 301};

    // directed words, '_' stands for the zero byte
    string dir_word [DIR_N] = '{
        "C", "r.", "v0", "t300", "32b#8.", "1cb1", "t", "_", "4", "xc", "v15"
    };
    t_dir_row dir_rows [DIR_N] = '{
        '{1'b1, '{nwp_pkg::KIND_NOTE, 16'd262, 16'd500, 4'd12}},
        '{1'b1, '{nwp_pkg::KIND_NOTE, 16'd0, 16'd750, 4'd12}},
        '{1'b1, '{nwp_pkg::KIND_CTRL, 16'd0, 16'd0, 4'd0}},
        '{1'b1, '{nwp_pkg::KIND_CTRL, 16'd0, 16'd0, 4'd0}},
        '{1'b0, '0},
        '{1'b0, '0},
        '{1'b1, '{nwp_pkg::KIND_ERR, 16'd0, 16'd0, 4'd0}},
        '{1'b1, '{nwp_pkg::KIND_ERR, 16'd0, 16'd0, 4'd0}},
        '{1'b1, '{nwp_pkg::KIND_ERR, 16'd0, 16'd0, 4'd0}},
        '{1'b1, '{nwp_pkg::KIND_ERR, 16'd0, 16'd0, 4'd0}},
        '{1'b1, '{nwp_pkg::KIND_CTRL, 16'd0, 16'd0, 4'd15}}
    };

    function automatic int unsigned draw_wait();
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    // decimal digit into the saturating accumulator
    function automatic void add_digit(logic [7:0] c);
        int unsigned v;
        v = digit_acc * 10 + (c - "0");
        digit_acc = (v > ACC_LIMIT) ? ACC_LIMIT[16:0] : 17'(v);
    endfunction

    // rest or note letter after the optional length
    function automatic void take_symbol(logic [7:0] c);
        int pc;
        case (c)
            "c": pc = 0;
            "d": pc = 2;
            "e": pc = 4;
            "f": pc = 5;
            "g": pc = 7;
            "a": pc = 9;
            "b": pc = 11;
            default: pc = -1;
        endcase
        if (c == "r") begin
            is_rest = 1'b1;
            word_phase = P_REST;
        end else if (pc >= 0) begin
            semitone = 5'(pc + 1);
            word_phase = P_NOTE;
        end else begin
            word_err = 1'b1;
        end
    endfunction

    function automatic void octave_or_dot(logic [7:0] c);
        if (c inside {["0":"9"]}) begin
            if (c < "1" || c > "8") word_err = 1'b1;
            else begin
                word_oct = 4'(c - "0");
                word_phase = P_OCT;
            end
        end else if (c == ".") begin
            dotted = 1'b1;
            word_phase = P_DOT;
        end else begin
            word_err = 1'b1;
        end
    endfunction

    // one accepted character; returns 1 with the result on a word end
    function automatic bit parse_note_char(input logic [7:0] raw, input logic last,
                                           output t_word_result res);
        logic [7:0]  c;
        bit          ok;
        int unsigned len, den, num, q, oct, idx;
        c = (raw inside {["A":"Z"]}) ? raw + 8'd32 : raw;
        res = '{nwp_pkg::KIND_ERR, 16'd0, 16'd0, 4'd0};
        if (char_cnt >= nwp_pkg::TOKEN_BUFFER_BYTES - 1) word_err = 1'b1;
        else char_cnt++;
        if (!word_err) begin
            case (word_phase)
                P_START: begin
                    if (c inside {"t", "o", "l", "v"}) begin
                        if (c == "t") ctl_sel = CTL_TEMPO;
                        else if (c == "o") ctl_sel = CTL_OCTAVE;
                        else if (c == "l") ctl_sel = CTL_LENGTH;
                        else ctl_sel = CTL_VOLUME;
                        word_phase = P_CWANT;
                    end else if (c inside {["0":"9"]}) begin
                        digit_acc = 17'd0;
                        add_digit(c);
                        word_phase = P_LEN;
                    end else begin
                        take_symbol(c);
                    end
                end
                P_LEN: begin
                    if (c inside {["0":"9"]}) add_digit(c);
                    else if (digit_acc < 1 || digit_acc > LENGTH_MAX) word_err = 1'b1;
                    else begin
                        word_len = 6'(digit_acc);
                        take_symbol(c);
                    end
                end
                P_CWANT, P_CTRL: begin
                    if (c inside {["0":"9"]}) begin
                        if (word_phase == P_CWANT) digit_acc = 17'd0;
                        add_digit(c);
                        word_phase = P_CTRL;
                    end else begin
                        word_err = 1'b1;
                    end
                end
                P_NOTE: begin
                    if (c == "#" || c == "s") begin
                        semitone++;
                        word_phase = P_ACC;
                    end else if (c == "b") begin
                        semitone--;
                        word_phase = P_ACC;
                    end else begin
                        octave_or_dot(c);
                    end
                end
                P_ACC: octave_or_dot(c);
                P_OCT, P_REST: begin
                    if (c == ".") begin
                        dotted = 1'b1;
                        word_phase = P_DOT;
                    end else begin
                        word_err = 1'b1;
                    end
                end
                default: word_err = 1'b1;
            endcase
        end
        if (!last) return 1'b0;

        // word end: control update, note event or error result
        if (!word_err) begin
            case (word_phase)
                P_CTRL: begin
                    ok = 1'b0;
                    case (ctl_sel)
                        CTL_TEMPO: if (digit_acc >= TEMPO_MIN && digit_acc <= TEMPO_MAX) begin
                            tempo_q = 9'(digit_acc);
                            ok = 1'b1;
                        end
                        CTL_OCTAVE: if (digit_acc >= 1 && digit_acc <= OCTAVE_MAX) begin
                            octave_q = 4'(digit_acc);
                            ok = 1'b1;
                        end
                        CTL_LENGTH: if (digit_acc >= 1 && digit_acc <= LENGTH_MAX) begin
                            length_q = 6'(digit_acc);
                            ok = 1'b1;
                        end
                        default: if (digit_acc <= VOLUME_MAX) begin
                            volume_q = 4'(digit_acc);
                            ok = 1'b1;
                        end
                    endcase
                    if (ok) res.kind = nwp_pkg::KIND_CTRL;
                end
                P_REST, P_NOTE, P_ACC, P_OCT, P_DOT: begin
                    res.kind = nwp_pkg::KIND_NOTE;
                    len = (word_len != 0) ? word_len : length_q;
                    den = tempo_q * len;
                    num = dotted ? 360000 : 240000;
                    if (den == 0) q = 65535;
                    else q = (2 * num + den) / (2 * den);
                    res.dur = (q > 65535) ? 16'hFFFF : 16'(q);
                    if (!is_rest) begin
                        oct = (word_oct != 0) ? word_oct : octave_q;
                        idx = (oct - 1) * 12 + semitone;
                        // equal temperament, index 0 is midi note 23
                        if (oct >= 1 && idx < nwp_pkg::FREQ_ENTRIES)
                            res.freq = 16'($rtoi(440.0 * (2.0 ** ((real'(idx) - 46.0) / 12.0))
                                                 + 0.5));
                    end
                end
                default: ;
            endcase
        end
        res.vol = volume_q;

        // per-word state back to its start values
        word_phase = P_START;
        char_cnt   = 5'd0;
        digit_acc  = 17'd0;
        word_len   = 6'd0;
        word_oct   = 4'd0;
        semitone   = 5'd0;
        dotted     = 1'b0;
        ctl_sel    = CTL_TEMPO;
        is_rest    = 1'b0;
        word_err   = 1'b0;
        return 1'b1;
    endfunction

    // append text, letters in random case
    task automatic push_text(input string s);
        logic [7:0] ch;
        for (int k = 0; k < s.len(); k++) begin
            ch = s[k];
            if (ch inside {["a":"z"]} && $urandom_range(0, 2) == 0) ch -= 8'd32;
            word_chars.push_back(ch);
        end
    endtask

    task automatic fill_random_word();
        int unsigned pick, val, n;
        word_chars.delete();
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            // note or rest with optional length
            if ($urandom_range(0, 1)) begin
                if ($urandom_range(0, 9) == 0)
                    val = $urandom_range(0, 1) ? 0 : $urandom_range(33, 99);
                else
                    val = $urandom_range(1, 32);
                push_text($sformatf("%0d", val));
            end
            if (pick < 40) begin
                push_text(string'(note_letters[$urandom_range(0, 6)]));
                if ($urandom_range(0, 4) < 2)
                    push_text(string'(accidentals[$urandom_range(0, 2)]));
                if ($urandom_range(0, 1)) begin
                    val = ($urandom_range(0, 9) == 0) ? 9 * $urandom_range(0, 1)
                                                      : $urandom_range(1, 8);
                    push_text($sformatf("%0d", val));
                end
            end else begin
                push_text("r");
            end
            if ($urandom_range(0, 2) == 0) push_text(".");
        end else if (pick < 75) begin
            // control word
            push_text(string'(ctl_letters[$urandom_range(0, 3)]));
            case ($urandom_range(0, 3))
                0: val = $urandom_range(0, 320);
                1: val = limit_vals[$urandom_range(0, 11)];
                2: val = $urandom_range(0, 16);
                default: val = $urandom_range(100000, 999999999);
            endcase
            push_text($sformatf("%0d", val));
        end else if (pick < 85) begin
            // broken sequence: corrupted, cut short, or a lone control letter
            push_text($sformatf("%0d", $urandom_range(1, 32)));
            push_text(string'(note_letters[$urandom_range(0, 6)]));
            push_text("4.");
            case ($urandom_range(0, 2))
                0: word_chars[$urandom_range(0, word_chars.size() - 1)] = 8'($urandom);
                1: word_chars = word_chars[0:$urandom_range(0, word_chars.size() - 2)];
                default: begin
                    word_chars.delete();
                    push_text(string'(ctl_letters[$urandom_range(0, 3)]));
                end
            endcase
        end else if (pick < 95) begin
            // raw bytes
            n = $urandom_range(1, 5);
            repeat (n) word_chars.push_back(8'($urandom_range(0, 255)));
        end else begin
            // control word padded with zeros around the buffer limit
            push_text(string'(ctl_letters[$urandom_range(0, 3)]));
            n = $urandom_range(14, 17) - 3;
            repeat (n) word_chars.push_back("0");
            push_text($sformatf("%02d", $urandom_range(1, 40)));
        end
    endtask

    // one character transfer, then its prediction
    task automatic send_char(input logic [7:0] ch, input logic last, input logic typed,
                             input t_word_result typed_res);
        int unsigned  gap;
        t_word_result got;
        gap = draw_wait();
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid  <= 1'b0;
            i_char_code <= 8'($urandom);
            i_last_char <= 1'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_code <= ch;
        i_last_char <= last;
        do @(posedge i_clk); while (o_in_stall);
        if (parse_note_char(ch, last, got)) pending_words.push_back(typed ? typed_res : got);
        chars_sent++;
    endtask

    task automatic send_word(input logic typed, input t_word_result typed_res);
        for (int k = 0; k < word_chars.size(); k++)
            send_char(word_chars[k], k == word_chars.size() - 1, typed, typed_res);
    endtask

    task automatic hold_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // stimulus
    initial begin
        int unsigned word_idx;
        word_idx = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words
        for (int r = 0; r < DIR_N; r++) begin
            word_chars.delete();
            for (int k = 0; k < dir_word[r].len(); k++)
                word_chars.push_back(dir_word[r][k] == "_" ? 8'h00 : dir_word[r][k]);
            send_word(dir_rows[r].typed, dir_rows[r].res);
        end

        // random words in chunks, some without idling, some after a full drain
        while (chars_sent < ITEM_TARGET) begin
            if (word_idx % CHUNK_WORDS == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                if ((word_idx / CHUNK_WORDS) % 4 == 1) begin
                    hold_input();
                    while (pending_words.size() != 0) @(posedge i_clk);
                end
            end
            fill_random_word();
            send_word(1'b0, '0);
            word_idx++;
        end

        hold_input();
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver stall toward the block
    always @(negedge i_clk) i_out_stall <= (out_wait != 0);

    // result check, receiver idling and watchdog
    always @(posedge i_clk) begin
        t_word_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_words.size() == 0) begin
                    $error("result transfer with no word pending");
                    mismatches++;
                end else begin
                    want = pending_words.pop_front();
                    if (o_word_kind !== want.kind) begin
                        $error("word_kind: expected %0d, got %0d", want.kind, o_word_kind);
                        mismatches++;
                    end
                    if (o_freq_hz !== want.freq) begin
                        $error("freq_hz: expected %0d, got %0d", want.freq, o_freq_hz);
                        mismatches++;
                    end
                    if (o_dur_ms !== want.dur) begin
                        $error("dur_ms: expected %0d, got %0d", want.dur, o_dur_ms);
                        mismatches++;
                    end
                    if (o_vol_level !== want.vol) begin
                        $error("vol_level: expected %0d, got %0d", want.vol, o_vol_level);
                        mismatches++;
                    end
                end
                out_wait = draw_wait();
            end else if (out_wait != 0) begin
                out_wait--;
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

endmodule

### files.f
+incdir+rtl
rtl/nwp_pkg.sv
rtl/nwp_ctrl.sv
rtl/nwp_datapath.sv
rtl/note_word_parser_unit.sv
rtl/nwp_checker.sv
tb/note_word_parser_unit_test.sv
